// ----- design/vra_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vra_pkg
// shared types and constants for the value rank assigner
// ----------------------------------------------------------------------------
package vra_pkg;

    localparam int C_MAX_ITEMS = 64;
    localparam int C_VALUE_W   = 32;
    localparam int C_RANK_W    = 6;
    localparam int C_CMD_AW    = 1;   // command queue holds 2 items
    localparam int C_RES_AW    = 2;   // result queue holds 4 items

    typedef struct packed {
        logic signed [C_VALUE_W-1:0] value;
        logic                        is_final;
    } t_in;

    typedef struct packed {
        logic [C_RANK_W-1:0] rank;
        logic                last_rank;
        logic                overflow;
    } t_out;

    // classified item handed from front to back
    typedef struct packed {
        logic signed [C_VALUE_W-1:0] value;
        logic                        is_final;
        logic                        drop;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_STORE,
        BK_EMIT
    } t_back_state;

endpackage

// ----- design/value_rank_assigner_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// value_rank_assigner_unit
// rank transform of a set of signed values, ranks emitted in load order
// ----------------------------------------------------------------------------
//
//  channel   | handshake            | payload
//  ----------+----------------------+------------------------------------
//  input     | push / full          | i_item   : value, is_final
//  result    | pop / empty          | o_result : rank, last_rank, overflow
//
//  the front takes one item per cycle while the 2-entry command queue has room
//  the first value of a set and any dropped value are taken in the idle state,
//    the k-th value after the first (k from 1) scans the k stored values one by
//    one through the single read port of the value store, then is stored
//  emission of n ranks stalls whenever the 4-entry result queue has no room
//  reset is synchronous and clears control only, there is no clearing pass
//  a full result queue stalls emission, a busy back fills the command queue
//
module value_rank_assigner_unit #(
    parameter int MAX_ITEMS = vra_pkg::C_MAX_ITEMS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  vra_pkg::t_in  i_item,
    output logic          empty,
    input  logic          pop,
    output vra_pkg::t_out o_result
);

    import vra_pkg::*;

    // slot index and count width, store address width
    localparam int CW    = $clog2(MAX_ITEMS + 1);
    localparam int AW    = $clog2(MAX_ITEMS);
    localparam int CMD_W = $bits(t_cmd) + CW;
    localparam int RES_W = $bits(t_out);

    // front to command queue
    logic          w_cmd_wr;
    t_cmd          w_cmd_in;
    logic [CW-1:0] w_cmd_idx_in;
    logic          w_cmd_full;

    // command queue to back
    logic [CMD_W-1:0] w_cmd_rdata;
    logic             w_cmd_empty;
    logic             w_cmd_rd;
    logic [C_CMD_AW:0] w_cmd_count;
    t_cmd             w_cmd_out;
    logic [CW-1:0]    w_cmd_idx_out;

    // back to result queue
    logic              w_res_wr;
    t_out              w_res_in;
    logic [RES_W-1:0]  w_res_rdata;
    logic [C_RES_AW:0] w_res_count;

    vra_front #(
        .MAX_ITEMS (MAX_ITEMS),
        .CW        (CW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_item     (i_item),
        .o_cmd_wr   (w_cmd_wr),
        .o_cmd      (w_cmd_in),
        .o_cmd_idx  (w_cmd_idx_in),
        .i_cmd_full (w_cmd_full)
    );

    // classified items wait here while the back is scanning, storing or emitting
    vra_fifo #(
        .WIDTH (CMD_W),
        .AW    (C_CMD_AW)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_cmd_wr),
        .i_wdata ({w_cmd_in, w_cmd_idx_in}),
        .i_rd    (w_cmd_rd),
        .o_rdata (w_cmd_rdata),
        .o_empty (w_cmd_empty),
        .o_count (w_cmd_count)
    );

    assign w_cmd_full    = (w_cmd_count == (C_CMD_AW+1)'(2 ** C_CMD_AW));
    assign w_cmd_out     = t_cmd'(w_cmd_rdata[CW +: $bits(t_cmd)]);
    assign w_cmd_idx_out = w_cmd_rdata[CW-1:0];

    vra_back #(
        .MAX_ITEMS (MAX_ITEMS),
        .CW        (CW),
        .AW        (AW),
        .RES_AW    (C_RES_AW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (w_cmd_empty),
        .o_cmd_rd    (w_cmd_rd),
        .i_cmd       (w_cmd_out),
        .i_cmd_idx   (w_cmd_idx_out),
        .i_res_count (w_res_count),
        .o_res_wr    (w_res_wr),
        .o_res       (w_res_in)
    );

    // results wait here for the consumer, the back reserves room before reading
    vra_fifo #(
        .WIDTH (RES_W),
        .AW    (C_RES_AW)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_res_wr),
        .i_wdata (w_res_in),
        .i_rd    (pop),
        .o_rdata (w_res_rdata),
        .o_empty (empty),
        .o_count (w_res_count)
    );

    assign o_result = t_out'(w_res_rdata);

endmodule

// ----- design/vra_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vra_fifo
// small first-in first-out queue with a fill count
// ----------------------------------------------------------------------------
module vra_fifo #(
    parameter int WIDTH = 8,
    parameter int AW    = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty,
    output logic [AW:0]      o_count
);

    localparam int DEPTH = 2 ** AW;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, n_wp;
    logic [AW-1:0]    r_rp, n_rp;
    logic [AW:0]      r_cnt, n_cnt;
    logic             w_full;
    logic             w_wr, w_rd;

    assign o_empty = (r_cnt == '0);
    assign w_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_count = r_cnt;
    assign o_rdata = r_mem[r_rp];

    assign w_wr = i_wr && !w_full;
    assign w_rd = i_rd && !o_empty;

    always_comb begin
        n_wp  = w_wr ? r_wp + AW'(1) : r_wp;
        n_rp  = w_rd ? r_rp + AW'(1) : r_rp;
        n_cnt = r_cnt + (AW+1)'(w_wr) - (AW+1)'(w_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

// ----- design/vra_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vra_front
// accepts items, assigns store slots and marks items beyond capacity
// ----------------------------------------------------------------------------
module vra_front #(
    parameter int MAX_ITEMS = 64,
    parameter int CW        = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  vra_pkg::t_in  i_item,
    output logic          o_cmd_wr,
    output vra_pkg::t_cmd o_cmd,
    output logic [CW-1:0] o_cmd_idx,
    input  logic          i_cmd_full
);

    import vra_pkg::*;

    logic [CW-1:0] r_cnt, n_cnt;
    logic          w_accept;
    logic          w_drop;

    assign o_full   = i_cmd_full;
    assign w_accept = i_push && !i_cmd_full;
    assign w_drop   = (r_cnt == CW'(MAX_ITEMS));

    assign o_cmd_wr       = w_accept;
    assign o_cmd.value    = i_item.value;
    assign o_cmd.is_final = i_item.is_final;
    assign o_cmd.drop     = w_drop;
    assign o_cmd_idx      = r_cnt;

    // slot count restarts with every set
    always_comb begin
        n_cnt = r_cnt;
        if (w_accept) begin
            if (i_item.is_final) begin
                n_cnt = '0;
            end else if (!w_drop) begin
                n_cnt = r_cnt + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

// ----- design/vra_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vra_back
// rank update sequencer over the value and rank stores, and rank emission
// ----------------------------------------------------------------------------
module vra_back #(
    parameter int MAX_ITEMS = 64,
    parameter int CW        = 7,
    parameter int AW        = 6,
    parameter int RES_AW    = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_empty,
    output logic          o_cmd_rd,
    input  vra_pkg::t_cmd i_cmd,
    input  logic [CW-1:0] i_cmd_idx,
    input  logic [RES_AW:0] i_res_count,
    output logic          o_res_wr,
    output vra_pkg::t_out o_res
);

    import vra_pkg::*;

    localparam int RES_DEPTH = 2 ** RES_AW;

    t_back_state r_state, n_state;

    logic signed [C_VALUE_W-1:0] r_value, n_value;
    logic                        r_final, n_final;
    logic [CW-1:0]               r_n, n_n;
    logic [CW-1:0]               r_iss, n_iss;
    logic [CW-1:0]               r_wk, n_wk;
    logic                        r_rd_valid, n_rd_valid;
    logic [AW-1:0]               r_below, n_below;
    logic                        r_ovf, n_ovf;

    logic signed [C_VALUE_W-1:0] r_val_mem [MAX_ITEMS];
    logic [AW-1:0]               r_rank_mem [MAX_ITEMS];
    logic signed [C_VALUE_W-1:0] r_val_rd;
    logic [AW-1:0]               r_rank_rd;

    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic                        val_we;
    logic [AW-1:0]               val_wa;
    logic signed [C_VALUE_W-1:0] val_wd;
    logic                        rank_we;
    logic [AW-1:0]               rank_wa;
    logic [AW-1:0]               rank_wd;

    logic                        w_take;
    logic                        w_last_data;
    logic                        w_more;
    logic                        w_room;

    assign w_take      = (r_state == BK_IDLE) && !i_cmd_empty;
    assign w_last_data = r_rd_valid && (r_wk == r_n - CW'(1));
    assign w_more      = (r_iss < r_n);
    assign w_room      = ((RES_AW+2)'(i_res_count) + (RES_AW+2)'(r_rd_valid))
                         < (RES_AW+2)'(RES_DEPTH);

    assign o_cmd_rd = w_take;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (w_take) begin
                    if (i_cmd.drop || i_cmd_idx == '0) begin
                        n_state = i_cmd.is_final ? BK_EMIT : BK_IDLE;
                    end else begin
                        n_state = BK_SCAN;
                    end
                end
            end
            BK_SCAN: begin
                if (w_last_data) begin
                    n_state = BK_STORE;
                end
            end
            BK_STORE: begin
                n_state = r_final ? BK_EMIT : BK_IDLE;
            end
            BK_EMIT: begin
                if (w_last_data) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_value    = r_value;
        n_final    = r_final;
        n_n        = r_n;
        n_iss      = r_iss;
        n_wk       = r_wk;
        n_rd_valid = 1'b0;
        n_below    = r_below;
        n_ovf      = r_ovf;
        rd_en      = 1'b0;
        rd_addr    = r_iss[AW-1:0];
        val_we     = 1'b0;
        val_wa     = r_n[AW-1:0];
        val_wd     = r_value;
        rank_we    = 1'b0;
        rank_wa    = r_wk[AW-1:0];
        rank_wd    = r_rank_rd + AW'(1);
        o_res_wr   = 1'b0;
        o_res.rank      = C_RANK_W'(r_rank_rd);
        o_res.last_rank = (r_wk == r_n - CW'(1));
        o_res.overflow  = r_ovf;
        case (r_state)
            BK_IDLE: begin
                if (w_take) begin
                    n_value = i_cmd.value;
                    n_final = i_cmd.is_final;
                    n_iss   = '0;
                    n_below = '0;
                    if (i_cmd.drop) begin
                        n_ovf = 1'b1;
                        n_n   = i_cmd_idx;
                    end else if (i_cmd_idx == '0) begin
                        // first value of a set goes straight in with rank zero
                        val_we  = 1'b1;
                        val_wa  = '0;
                        val_wd  = i_cmd.value;
                        rank_we = 1'b1;
                        rank_wa = '0;
                        rank_wd = '0;
                        n_n     = CW'(1);
                    end else begin
                        n_n = i_cmd_idx;
                    end
                end
            end
            BK_SCAN: begin
                if (w_more) begin
                    rd_en      = 1'b1;
                    n_iss      = r_iss + CW'(1);
                    n_wk       = r_iss;
                    n_rd_valid = 1'b1;
                end
                if (r_rd_valid) begin
                    if (r_val_rd < r_value) begin
                        n_below = r_below + AW'(1);
                    end else begin
                        rank_we = 1'b1;
                    end
                end
            end
            BK_STORE: begin
                val_we  = 1'b1;
                rank_we = 1'b1;
                rank_wa = r_n[AW-1:0];
                rank_wd = r_below;
                n_n     = r_n + CW'(1);
                n_iss   = '0;
            end
            BK_EMIT: begin
                if (w_more && w_room) begin
                    rd_en      = 1'b1;
                    n_iss      = r_iss + CW'(1);
                    n_wk       = r_iss;
                    n_rd_valid = 1'b1;
                end
                if (r_rd_valid) begin
                    o_res_wr = 1'b1;
                end
                if (w_last_data) begin
                    n_ovf = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BK_IDLE;
            r_rd_valid <= 1'b0;
            r_ovf      <= 1'b0;
            r_n        <= '0;
            r_iss      <= '0;
            r_wk       <= '0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= n_rd_valid;
            r_ovf      <= n_ovf;
            r_n        <= n_n;
            r_iss      <= n_iss;
            r_wk       <= n_wk;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_final <= n_final;
        r_below <= n_below;
    end

    // value and rank stores, one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_val_rd  <= r_val_mem[rd_addr];
            r_rank_rd <= r_rank_mem[rd_addr];
        end
        if (val_we) begin
            r_val_mem[val_wa] <= val_wd;
        end
        if (rank_we) begin
            r_rank_mem[rank_wa] <= rank_wd;
        end
    end

endmodule

// ----- design/vra_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vra_checker
// port-level checks on the value rank assigner
// ----------------------------------------------------------------------------
module vra_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          full,
    input logic          empty,
    input logic          pop,
    input vra_pkg::t_out o_result
);

    import vra_pkg::*;

    // no result waits right after reset
    a_empty_after_reset : assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("results shown after reset");

    // input side open right after reset
    a_room_after_reset : assert property (@(posedge i_clk)
        !i_rst_n |=> !full)
        else $error("full after reset");

    // a waiting result holds until taken
    a_result_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> $stable(o_result))
        else $error("waiting result changed");

    // overflow flag is the same on every result of one set
    a_ovf_per_set : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && pop && !o_result.last_rank ##1 !empty
        |-> o_result.overflow == $past(o_result.overflow))
        else $error("overflow flag changed within a set");

endmodule

bind value_rank_assigner_unit vra_checker u_vra_checker (.*);

// ----- bench/value_rank_assigner_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// value_rank_assigner_unit_test
// self-checking bench for the rank transform unit: sets of signed values go
// in through the push side, a local model predicts the rank of every stored
// value in load order, and each popped result is checked field by field
// ----------------------------------------------------------------------------
module value_rank_assigner_unit_test;

    import vra_pkg::*;

    localparam int                      C_CYCLE_LIMIT  = 300000;
    localparam int                      C_RANDOM_ITEMS = 10;
    localparam int                      C_DRAIN_CYCLES = 150;
    localparam int                      C_LONG_HOLD    = 400;
    localparam logic signed [C_VALUE_W-1:0] C_INT_MIN  = 32'sh8000_0000;
    localparam logic signed [C_VALUE_W-1:0] C_INT_MAX  = 32'sh7fff_ffff;

    // dut signals, all inputs known from time zero
    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  push    = 1'b0;
    logic  pop     = 1'b0;
    t_in   i_item  = '0;
    logic  full;
    logic  empty;
    t_out  o_result;

    // local copy of the set being loaded
    logic signed [C_VALUE_W-1:0] set_values [C_MAX_ITEMS];
    logic [C_RANK_W-1:0]         set_ranks  [C_MAX_ITEMS];
    int                          set_count;
    logic                        set_overflow;

    // ranks still owed by the block, oldest first
    t_out rank_q [$];

    // bookkeeping
    int   errors          = 0;
    int   cycle_count     = 0;
    int   items_sent      = 0;
    int   sets_sent       = 0;
    int   overflow_sets   = 0;
    int   results_checked = 0;
    int   full_stalls     = 0;

    // idling controls, shared between the sides
    logic tx_idle_on  = 1'b0;
    logic rx_idle_on  = 1'b0;
    int   rx_hold_req = 0;
    int   rx_hold_left = 0;
    t_out rx_expect;

    always #1 i_clk = ~i_clk;

    value_rank_assigner_unit u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    // ------------------------------------------------------------------------
    // rank model
    // ------------------------------------------------------------------------

    // clear the set once its ranks have been handed out
    function automatic void clear_rank_set();
        for (int k = 0; k < C_MAX_ITEMS; k++) begin
            set_ranks[k] = '0;
        end
        set_count    = 0;
        set_overflow = 1'b0;
    endfunction

    // fold one accepted item into the set and queue the ranks it releases
    function automatic void predict_ranks(input t_in it);
        int   below;
        t_out res;
        below = 0;
        if (set_count >= C_MAX_ITEMS) begin
            // no room left, value dropped but the set is marked
            set_overflow = 1'b1;
        end else begin
            // stored values that are not below the new one move up a place
            for (int k = 0; k < set_count; k++) begin
                if (set_values[k] < it.value) begin
                    below++;
                end else begin
                    set_ranks[k] = set_ranks[k] + 1'b1;
                end
            end
            set_values[set_count] = it.value;
            set_ranks[set_count]  = C_RANK_W'(below);
            set_count++;
        end
        if (it.is_final) begin
            // one rank per stored value, in load order
            for (int k = 0; k < set_count; k++) begin
                res.rank      = set_ranks[k];
                res.last_rank = (k == set_count - 1);
                res.overflow  = set_overflow;
                rank_q.push_back(res);
            end
            if (set_overflow) begin
                overflow_sets++;
            end
            sets_sent++;
            clear_rank_set();
        end
    endfunction

    // ------------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------------

    // offer one item and wait for it to be taken; push is left high so that
    // back to back items need no second assignment in the same step
    task automatic send_item(input logic signed [C_VALUE_W-1:0] value, input logic is_final);
        t_in it;
        it.value    = value;
        it.is_final = is_final;
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) begin
            full_stalls++;
            @(posedge i_clk);
        end
        predict_ranks(it);
        items_sent++;
    endtask

    // mix of extremes, a narrow band that breeds ties, and full-width values
    function automatic logic signed [C_VALUE_W-1:0] pick_value();
        logic signed [C_VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = C_INT_MIN;
            1:       v = C_INT_MAX;
            2, 3, 4: v = $signed($urandom_range(0, 8)) - 4;
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // a whole set of random values, the last one flagged
    task automatic send_random_set(input int size);
        for (int k = 0; k < size; k++) begin
            send_item(pick_value(), k == size - 1);
        end
    endtask

    // sender stands still until every owed rank has come back
    task automatic wait_drained();
        push <= 1'b0;
        while (rank_q.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // receiver side and checking
    // ------------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            // an item moves when pop and not empty meet at this edge
            if (pop && !empty) begin
                if (rank_q.size() == 0) begin
                    $display("%0t: result with nothing expected, rank %0d last %0b ovf %0b",
                             $time, o_result.rank, o_result.last_rank, o_result.overflow);
                    errors++;
                end else begin
                    rx_expect = rank_q.pop_front();
                    if (o_result.rank !== rx_expect.rank) begin
                        $display("%0t: rank mismatch, expected %0d, actual %0d",
                                 $time, rx_expect.rank, o_result.rank);
                        errors++;
                    end
                    if (o_result.last_rank !== rx_expect.last_rank) begin
                        $display("%0t: last_rank mismatch, expected %0b, actual %0b",
                                 $time, rx_expect.last_rank, o_result.last_rank);
                        errors++;
                    end
                    if (o_result.overflow !== rx_expect.overflow) begin
                        $display("%0t: overflow mismatch, expected %0b, actual %0b",
                                 $time, rx_expect.overflow, o_result.overflow);
                        errors++;
                    end
                    results_checked++;
                end
            end
            // a long hold requested by a test wins over the random bursts
            if (rx_hold_left == 0 && rx_hold_req != 0) begin
                rx_hold_left = rx_hold_req;
                rx_hold_req  = 0;
            end else if (rx_hold_left == 0 && rx_idle_on && $urandom_range(0, 5) == 0) begin
                rx_hold_left = $urandom_range(1, 14);
            end
            if (rx_hold_left != 0) begin
                rx_hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > C_CYCLE_LIMIT) begin
            $display("%0t: run exceeded %0d cycles, %0d ranks still owed",
                     $time, C_CYCLE_LIMIT, rank_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // one-value sets at the edges of the range and around zero
    task automatic test_single_values();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_item(C_INT_MIN, 1'b1);
        send_item(C_INT_MAX, 1'b1);
        send_item('0, 1'b1);
        send_item(-1, 1'b1);
    endtask

    // ties, where the earlier copy must rank higher, and ordered runs
    task automatic test_ties();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        send_item(7, 1'b0);
        send_item(7, 1'b0);
        send_item(7, 1'b1);
        // repeated most negative and most positive values
        send_item(C_INT_MIN, 1'b0);
        send_item(C_INT_MIN, 1'b0);
        send_item(C_INT_MAX, 1'b0);
        send_item(C_INT_MAX, 1'b0);
        send_item(-1, 1'b0);
        send_item(0, 1'b0);
        send_item(1, 1'b1);
        // strictly rising, then strictly falling
        send_item(-2, 1'b0);
        send_item(-1, 1'b0);
        send_item(0, 1'b0);
        send_item(1, 1'b1);
        send_item(32'sh5555_5555, 1'b0);
        send_item(32'sh2aaa_aaaa, 1'b0);
        send_item(32'shaaaa_aaaa, 1'b1);
    endtask

    // a set that runs past capacity, one dropped value without the flag
    // and then the final flag on a dropped value
    task automatic test_capacity();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        for (int k = 0; k < C_MAX_ITEMS + 2; k++) begin
            send_item(pick_value(), k == C_MAX_ITEMS + 1);
        end
    endtask

    // receiver stops for a long stretch while items keep coming, so the
    // result side backs up into the input; then the sender waits it out
    task automatic test_back_pressure();
        tx_idle_on  = 1'b0;
        rx_idle_on  = 1'b0;
        rx_hold_req = C_LONG_HOLD;
        send_random_set(5);
        send_random_set(3);
        wait_drained();
    endtask

    // random small sets
    task automatic test_random_sets();
        int start_items;
        int size;
        start_items = items_sent;
        while (items_sent - start_items < C_RANDOM_ITEMS) begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            size = $urandom_range(1, 6);
            send_random_set(size);
        end
    endtask

    // closing stretch at full rate on both sides
    task automatic test_full_rate();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        for (int n = 0; n < 2; n++) begin
            send_random_set($urandom_range(1, 6));
        end
    endtask

    initial begin
        clear_rank_set();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_values();
        test_ties();
        test_capacity();
        test_back_pressure();
        test_random_sets();
        test_full_rate();

        // let everything owed come back, then watch for strays
        wait_drained();
        repeat (C_DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d items in %0d sets (%0d over capacity), %0d ranks checked",
                 items_sent, sets_sent, overflow_sets, results_checked);
        $display("input held off by a full block on %0d edges, %0d errors",
                 full_stalls, errors);
        if (errors == 0 && rank_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/vra_pkg.sv
design/vra_fifo.sv
design/vra_front.sv
design/vra_back.sv
design/value_rank_assigner_unit.sv
design/vra_checker.sv
bench/value_rank_assigner_unit_test.sv
